// ===== rtl/clit_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package clit_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W       = 9;
  localparam int CMP_W       = (ENT_W > CNT_W) ? ENT_W : CNT_W;
  localparam int SLOT_W      = 8;
  localparam int POS_W       = 32;
  localparam int VAL_W       = 16;
  localparam int FRAC_W      = 16;
  localparam int QUO_W       = 32;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int PROD_W      = VAL_W + QUO_W;
  localparam int RES_W       = 32;
  localparam int REGION_W    = 2;
  localparam int IN_DATA_W   = SLOT_W + POS_W + VAL_W + POS_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [REGION_W-1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_MIN      = 2'd1,
    REGION_MAX      = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_MIN,
    RES_MAX,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     capture;
    logic     scan_clr;
    logic     scan_minmax;
    logic     scan_search;
    logic     div_init;
    logic     div_step;
    logic     mul;
    res_sel_t res_sel;
    logic     out_load;
  } clit_cmd_t;

  typedef struct packed {
    logic minmax_last;
    logic search_hit;
    logic search_last;
    logic q_le_min;
    logic q_ge_max;
    logic out_free;
  } clit_stat_t;

endpackage

// ===== rtl/clamped_linear_interpolation_table_top.sv =====
// Top level of the clamped piecewise-linear interpolation table.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  s_axis   | s_axis_tvalid/tready      | tdata: entry_index, entry_position,
//           |                           |   entry_value, query_position; tuser: req_type;
//           |                           |   tlast: last_query
//  m_axis   | m_axis_tvalid/tready      | tdata: interpolated_value; tuser: region;
//           |                           |   tlast: last_result
//  cfg      | cfg_valid/cfg_ready       | cfg_data: entries_in_use
//
// A load beat writes the knot memory directly.
// A query beat with n knots in use reads the single-port knot memory one knot
// per cycle: one pass when it clamps, two when it interpolates, followed by a
// bit-serial divider over the 32 quotient bits, a multiply and a sum. Input is
// taken one beat at a time.
// A finished result waits in the output register; the next beat is accepted
// meanwhile and only the final hand-off stalls on m_axis_tready.
// rst is synchronous and active high; entries_in_use resets to 1, the knot
// memory is not cleared and needs no clearing pass.
module clamped_linear_interpolation_table_top
  import clit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] entry_index, [39:8] entry_position, [55:40] entry_value,
  // [87:56] query_position
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // [0] req_type
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] interpolated_value
  output logic [RES_W-1:0]     m_axis_tdata,
  // [1:0] region
  output logic [REGION_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast,
  // configuration write: entries_in_use
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ENT_W-1:0]     cfg_data
);

  clit_cmd_t  cmd;
  clit_stat_t stat;

  // entries_in_use is sampled at query start, so the register takes writes anytime
  assign cfg_ready = 1'b1;

  clit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clit_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_region (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

// ===== rtl/clit_dpath.sv =====
// Datapath: knot memory, min/max and interval scans, serial divider, output register.
module clit_dpath
  import clit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  clit_cmd_t            cmd,
  output clit_stat_t           stat,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic                 in_last,
  input  logic                 cfg_valid,
  input  logic [ENT_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [RES_W-1:0]     out_data,
  output logic [REGION_W-1:0]  out_region,
  output logic                 out_last
);

  // input fields
  logic        [SLOT_W-1:0] in_slot;
  logic signed [POS_W-1:0]  in_pos;
  logic signed [VAL_W-1:0]  in_val;
  logic signed [POS_W-1:0]  in_qpos;

  assign in_slot = in_data[SLOT_W-1:0];
  assign in_pos  = $signed(in_data[SLOT_W+POS_W-1:SLOT_W]);
  assign in_val  = $signed(in_data[SLOT_W+POS_W+VAL_W-1:SLOT_W+POS_W]);
  assign in_qpos = $signed(in_data[IN_DATA_W-1:SLOT_W+POS_W+VAL_W]);

  logic [ENT_W-1:0] entries;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_q;
  logic signed [POS_W-1:0] q;
  logic last_q;

  always_comb begin
    if (entries == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(entries) > CMP_W'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(entries);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= ENT_W'(1);
    end else if (cfg_valid) begin
      entries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_q    <= n_eff;
      q      <= in_qpos;
      last_q <= in_last;
    end
  end

  // knot memory: {value, position}
  logic [VAL_W+POS_W-1:0] mem [TABLE_DEPTH];
  logic [VAL_W+POS_W-1:0] rd_word;
  logic                   load_ok;

  assign load_ok = (32'(in_slot) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[IDX_W'(in_slot)] <= {in_val, in_pos};
    end
  end

  // scan address and read pipeline
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] ridx;
  logic             rvalid;
  logic             issue;

  assign issue = (cmd.scan_minmax || cmd.scan_search) && (cnt < n_q);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= issue;
      if (cmd.scan_clr) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ridx <= cnt;
    end
  end

  logic signed [POS_W-1:0] rd_pos;
  logic signed [VAL_W-1:0] rd_val;
  assign rd_pos = $signed(rd_word[POS_W-1:0]);
  assign rd_val = $signed(rd_word[VAL_W+POS_W-1:POS_W]);

  // min/max scan, first occurrence wins
  logic signed [POS_W-1:0] minx, maxx;
  logic signed [VAL_W-1:0] minv, maxv;

  always_ff @(posedge clk) begin
    if (cmd.scan_minmax && rvalid) begin
      if (ridx == '0) begin
        minx <= rd_pos;
        maxx <= rd_pos;
        minv <= rd_val;
        maxv <= rd_val;
      end else if (rd_pos < minx) begin
        minx <= rd_pos;
        minv <= rd_val;
      end else if (rd_pos > maxx) begin
        maxx <= rd_pos;
        maxv <= rd_val;
      end
    end
  end

  // interval search: previous knot vs current knot
  logic signed [POS_W-1:0] prev_pos;
  logic signed [VAL_W-1:0] prev_val;
  logic signed [POS_W-1:0] x0, x1;
  logic signed [VAL_W-1:0] y0, y1;
  logic                    hit;

  assign hit = rvalid && (ridx != '0) && (prev_pos <= q) && (q < rd_pos);

  always_ff @(posedge clk) begin
    if (rvalid) begin
      prev_pos <= rd_pos;
      prev_val <= rd_val;
    end
    if (cmd.scan_search && hit) begin
      x0 <= prev_pos;
      x1 <= rd_pos;
      y0 <= prev_val;
      y1 <= rd_val;
    end
  end

  // restoring division: u = floor(num * 2^32 / den), num < den
  logic [POS_W-1:0] den;
  logic [POS_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [POS_W:0]   rem2;
  logic             qbit;

  assign rem2 = {rem, 1'b0};
  assign qbit = (rem2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= POS_W'(q - x0);
      den <= POS_W'(x1 - x0);
    end else if (cmd.div_step) begin
      rem <= qbit ? POS_W'(rem2 - {1'b0, den}) : rem2[POS_W-1:0];
      quo <= {quo[QUO_W-2:0], qbit};
    end
  end

  // step = sign(dy) * ((|dy| * u) >> 16)
  logic signed [VAL_W:0] dy;
  logic [VAL_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic                  dy_neg;

  assign dy = {y1[VAL_W-1], y1} - {y0[VAL_W-1], y0};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mag    <= dy[VAL_W] ? VAL_W'(-dy) : VAL_W'(dy);
      dy_neg <= dy[VAL_W];
    end
  end

  logic [RES_W-1:0] part;
  logic [RES_W-1:0] interp;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mag) * PROD_W'(quo);
  end

  assign part   = prod[FRAC_W+RES_W-1:FRAC_W];
  assign interp = {y0, {FRAC_W{1'b0}}} + (dy_neg ? (~part + RES_W'(1)) : part);

  // result register
  logic [RES_W-1:0] res;
  region_t          res_region;

  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      RES_MIN: begin
        res        <= {minv, {FRAC_W{1'b0}}};
        res_region <= REGION_MIN;
      end
      RES_MAX: begin
        res        <= {maxv, {FRAC_W{1'b0}}};
        res_region <= REGION_MAX;
      end
      RES_INTERP: begin
        res        <= interp;
        res_region <= REGION_INTERIOR;
      end
      default: begin
      end
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data   <= res;
      out_region <= res_region;
      out_last   <= last_q;
    end
  end

  assign stat.minmax_last = rvalid && (ridx == n_q - CNT_W'(1));
  assign stat.search_last = rvalid && (ridx == n_q - CNT_W'(1));
  assign stat.search_hit  = hit;
  assign stat.q_le_min    = (q <= minx);
  assign stat.q_ge_max    = (q >= maxx);
  assign stat.out_free    = !out_valid || out_ready;

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (ridx < n_q))
    else $error("scan read beyond entries in use");

  a_interval_rising: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_search && hit) |=> (x1 > x0))
    else $error("captured interval does not rise");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < den))
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/clit_ctrl.sv =====
// Controller: sequences load, min/max scan, interval search, division and output.
module clit_ctrl
  import clit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  clit_stat_t stat,
  output clit_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MINMAX,
    S_DECIDE,
    S_SEARCH,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_PROD,
    S_SUM,
    S_DONE
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture  = 1'b1;
            cmd.scan_clr = 1'b1;
            state_next   = S_MINMAX;
          end
        end
      end
      S_MINMAX: begin
        cmd.scan_minmax = 1'b1;
        if (stat.minmax_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.q_le_min) begin
          cmd.res_sel = RES_MIN;
          state_next  = S_DONE;
        end else if (stat.q_ge_max) begin
          cmd.res_sel = RES_MAX;
          state_next  = S_DONE;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.scan_search = 1'b1;
        if (stat.search_hit) begin
          state_next = S_DINIT;
        end else if (stat.search_last) begin
          // no rising interval around q: fall back to the minimum knot
          cmd.res_sel = RES_MIN;
          state_next  = S_DONE;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == STEP_W'(QUO_W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        // product register picks up the new magnitude
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.res_sel = RES_INTERP;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state) == S_DIV && $past(step_cnt) == STEP_W'(QUO_W - 1)))
    else $error("divider left early");

endmodule
